[src/stt_pkg.sv]
// shared types and defaults for the sorted timer table
package stt_pkg;

  localparam int unsigned NumTimersDef = 16;
  localparam int unsigned TimeBitsDef  = 40;
  localparam int unsigned OwnerBitsDef = 16;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EXPIRE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_TK_RD,
    S_TK_WR,
    S_XP_RD,
    S_XP_EM,
    S_EMIT
  } state_e;

endpackage

[src/stt_ram.sv]
// single-port-write, single-port-read memory with registered read data
module stt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/sorted_timer_table.sv]
// sorted timer table: sequencer over an entry memory and an expiry list memory
// one transaction at a time; in_stall_o is high from acceptance until the work is done
// add: shifts entries up one slot at a time to place the timer; when full, ST_FULL
// delete: drops the owner's entries and compacts the rest; tick: subtracts elapsed time,
// emits one ST_EXPIRE per expired timer, re-adds periodic ones; output stalls hold results
// reset empties the table at once (the fill count clears); no memory sweep is needed
module sorted_timer_table #(
  parameter int unsigned NUM_TIMERS = stt_pkg::NumTimersDef,
  parameter int unsigned TIME_BITS  = stt_pkg::TimeBitsDef,
  parameter int unsigned OWNER_BITS = stt_pkg::OwnerBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [TIME_BITS-1:0]                period_us_i,
  input  logic                                periodic_i,
  input  logic [OWNER_BITS-1:0]               owner_i,
  input  logic [TIME_BITS-1:0]                elapsed_us_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [OWNER_BITS-1:0]               expired_owner_o,
  output logic [$clog2(NUM_TIMERS+1)-1:0]     removed_count_o,
  output logic                                last_o
);
  import stt_pkg::*;

  localparam int unsigned CntW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned IdxW = $clog2(NUM_TIMERS);
  localparam int unsigned EW   = OWNER_BITS + 2 * TIME_BITS + 1;
  localparam int unsigned XW   = OWNER_BITS + TIME_BITS + 1;

  state_e state_q, state_d;
  logic [CntW-1:0] n_q, n_d, i_q, i_d, j_q, j_d, k_q, k_d, p_q, p_d, r_q, r_d;
  logic expiring_q, expiring_d, xp_phase_q, xp_phase_d;
  logic [OWNER_BITS-1:0] ins_own_q, ins_own_d;
  logic [TIME_BITS-1:0]  ins_per_q, ins_per_d, el_q, el_d;
  logic ins_pf_q, ins_pf_d;
  logic [1:0] em_st_q, em_st_d;
  logic [OWNER_BITS-1:0] em_own_q, em_own_d;
  logic [CntW-1:0] em_cnt_q, em_cnt_d;
  logic em_last_q, em_last_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] out_st_q, out_st_d;
  logic [OWNER_BITS-1:0] out_own_q, out_own_d;
  logic [CntW-1:0] out_cnt_q, out_cnt_d;
  logic out_last_q, out_last_d;

  logic            m_we;
  logic [IdxW-1:0] m_waddr, m_raddr;
  logic [EW-1:0]   m_wdata, m_rdata;
  logic            x_we;
  logic [XW-1:0]   x_wdata, x_rdata;

  logic [OWNER_BITS-1:0] rd_own;
  logic [TIME_BITS-1:0]  rd_per, rd_rem;
  logic                  rd_pf;
  logic [CntW-1:0]       pm1, iminusk;
  logic                  accept, slot_free, rd_expires;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign pm1        = p_q - 1'b1;
  assign iminusk    = i_q - k_q;

  assign rd_pf  = m_rdata[0];
  assign rd_rem = m_rdata[TIME_BITS:1];
  assign rd_per = m_rdata[2*TIME_BITS:TIME_BITS+1];
  assign rd_own = m_rdata[EW-1:2*TIME_BITS+1];
  assign rd_expires = expiring_q && (rd_rem <= el_q);

  stt_ram #(.Width(EW), .Depth(NUM_TIMERS)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  stt_ram #(.Width(XW), .Depth(NUM_TIMERS)) u_expiry_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (k_q[IdxW-1:0]),
    .wdata_i (x_wdata),
    .raddr_i (r_q[IdxW-1:0]),
    .rdata_o (x_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (command_i == CMD_ADD) begin
            state_d = (n_q == CntW'(NUM_TIMERS)) ? S_EMIT : S_INS_RD;
          end else if (command_i == CMD_DEL) begin
            state_d = S_DEL_RD;
          end else if (command_i == CMD_TICK) begin
            state_d = S_TK_RD;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_INS_RD: state_d = (p_q == '0) ? (xp_phase_q ? S_XP_RD : S_EMIT) : S_INS_WR;
      S_INS_WR: begin
        if (rd_rem > ins_per_q) begin
          state_d = S_INS_RD;
        end else begin
          state_d = xp_phase_q ? S_XP_RD : S_EMIT;
        end
      end
      S_DEL_RD: state_d = (i_q == n_q) ? S_EMIT : S_DEL_WR;
      S_DEL_WR: state_d = S_DEL_RD;
      S_TK_RD: begin
        if (i_q != n_q) begin
          state_d = S_TK_WR;
        end else begin
          state_d = (k_q == '0) ? S_EMIT : S_XP_RD;
        end
      end
      S_TK_WR: state_d = S_TK_RD;
      S_XP_RD: state_d = (r_q == k_q) ? S_IDLE : S_XP_EM;
      S_XP_EM: state_d = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          if (xp_phase_q) begin
            state_d = ins_pf_q ? S_INS_RD : S_XP_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    m_we    = 1'b0;
    m_waddr = '0;
    m_wdata = m_rdata;
    m_raddr = '0;
    x_we    = 1'b0;
    x_wdata = {rd_own, rd_per, rd_pf};
    case (state_q)
      S_INS_RD: begin
        m_raddr = pm1[IdxW-1:0];
        if (p_q == '0) begin
          m_we    = 1'b1;
          m_waddr = '0;
          m_wdata = {ins_own_q, ins_per_q, ins_per_q, ins_pf_q};
        end
      end
      S_INS_WR: begin
        m_we    = 1'b1;
        m_waddr = p_q[IdxW-1:0];
        if (rd_rem <= ins_per_q) begin
          m_wdata = {ins_own_q, ins_per_q, ins_per_q, ins_pf_q};
        end
      end
      S_DEL_RD: m_raddr = i_q[IdxW-1:0];
      S_DEL_WR: begin
        m_we    = (rd_own != ins_own_q);
        m_waddr = j_q[IdxW-1:0];
      end
      S_TK_RD: m_raddr = i_q[IdxW-1:0];
      S_TK_WR: begin
        if (rd_expires) begin
          x_we = 1'b1;
        end else begin
          m_we    = 1'b1;
          m_waddr = iminusk[IdxW-1:0];
          m_wdata = {rd_own, rd_per, rd_rem - el_q, rd_pf};
        end
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    n_d = n_q; i_d = i_q; j_d = j_q; k_d = k_q; p_d = p_q; r_d = r_q;
    expiring_d = expiring_q;
    xp_phase_d = xp_phase_q;
    ins_own_d = ins_own_q; ins_per_d = ins_per_q; ins_pf_d = ins_pf_q;
    el_d = el_q;
    em_st_d = em_st_q; em_own_d = em_own_q; em_cnt_d = em_cnt_q; em_last_d = em_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_st_d = out_st_q; out_own_d = out_own_q; out_cnt_d = out_cnt_q; out_last_d = out_last_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ins_own_d  = owner_i;
          ins_per_d  = period_us_i;
          ins_pf_d   = periodic_i;
          el_d       = elapsed_us_i;
          i_d        = '0;
          j_d        = '0;
          k_d        = '0;
          p_d        = n_q;
          expiring_d = 1'b1;
          xp_phase_d = 1'b0;
          em_st_d    = ST_DONE;
          em_own_d   = '0;
          em_cnt_d   = '0;
          em_last_d  = 1'b1;
          if (command_i == CMD_ADD && n_q == CntW'(NUM_TIMERS)) begin
            em_st_d = ST_FULL;
          end
        end
      end
      S_INS_RD: begin
        if (p_q == '0) begin
          n_d = n_q + 1'b1;
        end
      end
      S_INS_WR: begin
        if (rd_rem > ins_per_q) begin
          p_d = pm1;
        end else begin
          n_d = n_q + 1'b1;
        end
      end
      S_DEL_RD: begin
        if (i_q == n_q) begin
          n_d      = j_q;
          em_cnt_d = n_q - j_q;
        end
      end
      S_DEL_WR: begin
        i_d = i_q + 1'b1;
        if (rd_own != ins_own_q) begin
          j_d = j_q + 1'b1;
        end
      end
      S_TK_RD: begin
        if (i_q == n_q) begin
          n_d        = n_q - k_q;
          r_d        = '0;
          xp_phase_d = (k_q != '0);
        end
      end
      S_TK_WR: begin
        i_d = i_q + 1'b1;
        if (rd_expires) begin
          k_d = k_q + 1'b1;
        end else begin
          expiring_d = 1'b0;
        end
      end
      S_XP_EM: begin
        ins_pf_d  = x_rdata[0];
        ins_per_d = x_rdata[TIME_BITS:1];
        ins_own_d = x_rdata[XW-1:TIME_BITS+1];
        em_st_d   = ST_EXPIRE;
        em_own_d  = x_rdata[XW-1:TIME_BITS+1];
        em_cnt_d  = '0;
        em_last_d = (r_q + 1'b1 == k_q);
        r_d       = r_q + 1'b1;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_st_d    = em_st_q;
          out_own_d   = em_own_q;
          out_cnt_d   = em_cnt_q;
          out_last_d  = em_last_q;
          p_d         = n_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      xp_phase_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      xp_phase_q  <= xp_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; k_q <= k_d; p_q <= p_d; r_q <= r_d;
    expiring_q <= expiring_d;
    ins_own_q <= ins_own_d; ins_per_q <= ins_per_d; ins_pf_q <= ins_pf_d;
    el_q <= el_d;
    em_st_q <= em_st_d; em_own_q <= em_own_d; em_cnt_q <= em_cnt_d; em_last_q <= em_last_d;
    out_st_q <= out_st_d; out_own_q <= out_own_d; out_cnt_q <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_st_q;
  assign expired_owner_o = out_own_q;
  assign removed_count_o = out_cnt_q;
  assign last_o          = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(NUM_TIMERS))
    else $error("fill count beyond table size");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !m_we && !x_we)
    else $error("memory written while idle");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && !slot_free) |=> (state_q == S_EMIT))
    else $error("result dropped while output busy");

  a_fill_grows_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_RD || state_q == S_INS_WR) |=> (n_q == $past(n_q)) ||
      (n_q == $past(n_q) + 1'b1))
    else $error("insert changed fill count by more than one");

endmodule
